FILE: sv/sbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

    localparam int WORD_W     = 64;
    localparam int HASH_WORDS = 8;
    localparam int WIN_DEPTH  = 16;
    localparam int ROUNDS     = 80;
    localparam int RND_W      = 7;
    localparam int WCNT_W     = 4;
    localparam int OIDX_W     = 3;
    localparam int CFG_IDX_W  = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [HASH_WORDS-1:0] hash_t;

    // Input transfer payload
    typedef struct packed {
        logic [WORD_W-1:0] message_word;
        logic              start_of_message;
        logic              end_of_message;
    } in_t;

    // Output transfer payload
    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [OIDX_W-1:0] digest_index;
        logic              last_word;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // Sequencer controls toward the schedule window and round unit
    typedef struct packed {
        logic             win_load;
        logic             win_expand;
        logic             cv_init;
        logic             wv_load;
        logic             wv_round;
        logic             cv_add;
        logic [RND_W-1:0] k_idx;
    } ctrl_t;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t bsig0(input word_t x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t bsig1(input word_t x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t ssig0(input word_t x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t ssig1(input word_t x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t ch(input word_t x, input word_t y, input word_t z);
        return (x & y) ^ (~x & z);
    endfunction

    function automatic word_t maj(input word_t x, input word_t y, input word_t z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

    // Round constants; indexes past the last round read as zero
    function automatic word_t round_k(input logic [RND_W-1:0] r);
        word_t k;
        case (r)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: sv/sbc_sched.sv
`timescale 1ns / 1ps
`default_nettype none

// Message schedule window: a 16-deep shift line. Input words shift in at the
// top; during rounds the expanded word W[t+16] shifts in while W[t] leaves.
module sbc_sched (
    input  wire logic          aclk,
    input  wire sbc_pkg::ctrl_t ctrl,
    input  wire sbc_pkg::word_t word_in,
    output sbc_pkg::word_t     w0,
    output sbc_pkg::word_t     w1
);

    sbc_pkg::word_t win_reg  [sbc_pkg::WIN_DEPTH];
    sbc_pkg::word_t win_next [sbc_pkg::WIN_DEPTH];
    sbc_pkg::word_t expand_word;

    // W[t+16] = s1(W[t+14]) + W[t+9] + s0(W[t+1]) + W[t]
    assign expand_word = sbc_pkg::ssig1(win_reg[14]) + win_reg[9]
                       + sbc_pkg::ssig0(win_reg[1]) + win_reg[0];

    always_comb begin
        win_next = win_reg;
        if (ctrl.win_load || ctrl.win_expand) begin
            for (int i = 0; i < sbc_pkg::WIN_DEPTH - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[sbc_pkg::WIN_DEPTH-1] = ctrl.win_load ? word_in : expand_word;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign w0 = win_reg[0];
    assign w1 = win_reg[1];

endmodule

`default_nettype wire

FILE: sv/sbc_round.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared round unit: working variables a..h, the precomputed h+K+W term for
// the next round, and the chaining value with its end-of-block add.
module sbc_round (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire sbc_pkg::ctrl_t ctrl,
    input  wire sbc_pkg::hash_t init_hash,
    input  wire sbc_pkg::word_t w0,
    input  wire sbc_pkg::word_t w1,
    output sbc_pkg::hash_t      chain
);

    sbc_pkg::hash_t wv_reg,  wv_next;
    sbc_pkg::hash_t cv_reg,  cv_next;
    sbc_pkg::word_t hkw_reg, hkw_next;
    sbc_pkg::word_t t1, t2, k_word;

    assign k_word = sbc_pkg::round_k(ctrl.k_idx);

    // One compression round; index 0 is a, index 7 is h
    assign t1 = hkw_reg + sbc_pkg::bsig1(wv_reg[4])
              + sbc_pkg::ch(wv_reg[4], wv_reg[5], wv_reg[6]);
    assign t2 = sbc_pkg::bsig0(wv_reg[0])
              + sbc_pkg::maj(wv_reg[0], wv_reg[1], wv_reg[2]);

    always_comb begin
        wv_next  = wv_reg;
        hkw_next = hkw_reg;
        if (ctrl.wv_load) begin
            wv_next  = cv_reg;
            hkw_next = cv_reg[7] + k_word + w0;
        end else if (ctrl.wv_round) begin
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
            // next round's h is today's g; its W is at window slot 1 now
            hkw_next   = wv_reg[6] + k_word + w1;
        end
    end

    // Chaining value: reload at message start, accumulate at block end
    always_comb begin
        cv_next = cv_reg;
        if (ctrl.cv_init) begin
            cv_next = init_hash;
        end else if (ctrl.cv_add) begin
            for (int i = 0; i < sbc_pkg::HASH_WORDS; i++) begin
                cv_next[i] = cv_reg[i] + wv_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        wv_reg  <= wv_next;
        hkw_reg <= hkw_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= '0;
        end else begin
            cv_reg <= cv_next;
        end
    end

    assign chain = cv_reg;

endmodule

`default_nettype wire

FILE: sv/sbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: collects 16 words, runs load / rounds / add, then drives out
// the digest when the block carried the end-of-message word.
module sbc_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        start_flag,
    input  wire logic                        end_flag,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [sbc_pkg::OIDX_W-1:0]       out_idx,
    output sbc_pkg::ctrl_t                   ctrl
);

    sbc_pkg::state_t                  state_reg,     state_next;
    logic [sbc_pkg::WCNT_W-1:0]       word_cnt_reg,  word_cnt_next;
    logic [sbc_pkg::RND_W-1:0]        round_cnt_reg, round_cnt_next;
    logic [sbc_pkg::OIDX_W-1:0]       out_idx_reg,   out_idx_next;
    logic                             end_pend_reg,  end_pend_next;
    logic [sbc_pkg::WCNT_W-1:0]       word_slot;
    logic                             in_xfer;
    logic                             out_xfer;
    logic                             last_round;
    logic                             block_full;

    assign in_xfer    = s_valid && s_ready;
    assign out_xfer   = m_valid && m_ready;
    assign word_slot  = start_flag ? '0 : word_cnt_reg;
    assign block_full = (word_slot == sbc_pkg::WCNT_W'(sbc_pkg::WIN_DEPTH - 1));
    assign last_round = (round_cnt_reg == sbc_pkg::RND_W'(sbc_pkg::ROUNDS - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbc_pkg::ST_IDLE: begin
                if (in_xfer && block_full) begin
                    state_next = sbc_pkg::ST_LOAD;
                end
            end
            sbc_pkg::ST_LOAD: begin
                state_next = sbc_pkg::ST_ROUND;
            end
            sbc_pkg::ST_ROUND: begin
                if (last_round) begin
                    state_next = sbc_pkg::ST_ADD;
                end
            end
            sbc_pkg::ST_ADD: begin
                state_next = end_pend_reg ? sbc_pkg::ST_OUT : sbc_pkg::ST_IDLE;
            end
            sbc_pkg::ST_OUT: begin
                if (out_xfer && (out_idx_reg == sbc_pkg::OIDX_W'(sbc_pkg::HASH_WORDS - 1))) begin
                    state_next = sbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Counters and pending end flag
    always_comb begin
        word_cnt_next  = word_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        end_pend_next  = end_pend_reg;
        if (in_xfer) begin
            word_cnt_next = word_slot + 1'b1;
            end_pend_next = (end_pend_reg && !start_flag) || end_flag;
        end
        if (state_reg == sbc_pkg::ST_LOAD) begin
            round_cnt_next = '0;
        end
        if (state_reg == sbc_pkg::ST_ROUND) begin
            round_cnt_next = last_round ? '0 : round_cnt_reg + 1'b1;
        end
        if (state_reg == sbc_pkg::ST_ADD) begin
            end_pend_next = 1'b0;
            out_idx_next  = '0;
        end
        if (out_xfer) begin
            out_idx_next = out_idx_reg + 1'b1;
        end
    end

    // Outputs; ready is high throughout idle, so a valid word is a transfer
    always_comb begin
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        ctrl            = '0;
        ctrl.k_idx      = '0;
        unique case (state_reg)
            sbc_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                ctrl.win_load = s_valid;
                ctrl.cv_init  = s_valid && start_flag;
            end
            sbc_pkg::ST_LOAD: begin
                ctrl.wv_load = 1'b1;
            end
            sbc_pkg::ST_ROUND: begin
                ctrl.wv_round   = 1'b1;
                ctrl.win_expand = 1'b1;
                ctrl.k_idx      = round_cnt_reg + 1'b1;
            end
            sbc_pkg::ST_ADD: begin
                ctrl.cv_add = 1'b1;
            end
            sbc_pkg::ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbc_pkg::ST_IDLE;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            end_pend_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            end_pend_reg  <= end_pend_next;
        end
    end

    assign out_idx = out_idx_reg;

endmodule

`default_nettype wire

FILE: sv/sha512_block_compress.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                              Moves
// s_        s_valid s_ready s_data (in_t)      one padded message word
// m_        m_valid m_ready m_data (out_t)     one digest word
// cfg_      cfg_valid cfg_ready cfg_index/data write of init_hash_0..7
//
// A word is taken whenever s_valid and s_ready are both high. The sixteenth
// word of a block starts the load state, the rounds on the shared round unit
// and the add state; s_ready is low meanwhile. A block with the end mark then
// holds for 8 digest transfers, paced by m_ready.
// Reset clears the chaining value, init registers and the sequencer.
module sha512_block_compress (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire sbc_pkg::in_t                    s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output sbc_pkg::out_t                        m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire sbc_pkg::word_t                  cfg_data
);

    sbc_pkg::hash_t              init_hash_reg, init_hash_next;
    sbc_pkg::hash_t              chain;
    sbc_pkg::ctrl_t              ctrl;
    sbc_pkg::word_t              w0, w1;
    logic [sbc_pkg::OIDX_W-1:0]  out_idx;

    // Initial hash registers; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        init_hash_next = init_hash_reg;
        if (cfg_valid && cfg_ready && (cfg_index < sbc_pkg::CFG_IDX_W'(sbc_pkg::HASH_WORDS))) begin
            init_hash_next[cfg_index[sbc_pkg::OIDX_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_hash_reg <= '0;
        end else begin
            init_hash_reg <= init_hash_next;
        end
    end

    sbc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .start_flag (s_data.start_of_message),
        .end_flag   (s_data.end_of_message),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .out_idx    (out_idx),
        .ctrl       (ctrl)
    );

    sbc_sched u_sched (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .word_in (s_data.message_word),
        .w0      (w0),
        .w1      (w1)
    );

    sbc_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .init_hash (init_hash_reg),
        .w0        (w0),
        .w1        (w1),
        .chain     (chain)
    );

    // Digest words come straight from the held chaining value
    assign m_data.digest_word  = chain[out_idx];
    assign m_data.digest_index = out_idx;
    assign m_data.last_word    = (out_idx == sbc_pkg::OIDX_W'(sbc_pkg::HASH_WORDS - 1));

endmodule

`default_nettype wire

FILE: bench/sha512_block_compress_tb.sv
`timescale 1ns / 1ps

// Tracks the chaining state of the compressor and holds the digest words
// that are due on the result channel, oldest first.
class digest_tracker;

    sbc_pkg::word_t  init_regs [sbc_pkg::HASH_WORDS];
    sbc_pkg::word_t  chain [sbc_pkg::HASH_WORDS];
    sbc_pkg::word_t  window [sbc_pkg::WIN_DEPTH];
    sbc_pkg::word_t  kconst [sbc_pkg::ROUNDS];
    logic [sbc_pkg::WCNT_W-1:0] fill;
    bit     end_seen;
    sbc_pkg::out_t   digests_due [$];
    int     fail_count;
    int     digests_predicted;

    function new();
        kconst = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
            64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
            64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
            64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
            64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
            64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
            64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
            64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
            64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
            64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
            64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
            64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
            64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
            64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
            64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
            64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
            64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
            64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
            64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
            64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
            64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
        };
        foreach (init_regs[i]) init_regs[i] = '0;
        foreach (chain[i]) chain[i] = '0;
        foreach (window[i]) window[i] = '0;
        fill = '0;
        end_seen = 1'b0;
        fail_count = 0;
        digests_predicted = 0;
    endfunction

    function sbc_pkg::word_t spin_right(sbc_pkg::word_t x, int n);
        logic [2*sbc_pkg::WORD_W-1:0] dbl;
        dbl = {x, x} >> n;
        return dbl[sbc_pkg::WORD_W-1:0];
    endfunction

    function void note_fail(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Unmapped indexes are dropped by the block
    function void write_reg(int idx, sbc_pkg::word_t val);
        if (idx < sbc_pkg::HASH_WORDS) begin
            init_regs[idx] = val;
        end
    endfunction

    // 80 rounds over the filled window, then fold into the chaining value
    function void run_rounds();
        sbc_pkg::word_t v [sbc_pkg::HASH_WORDS];
        sbc_pkg::word_t w [sbc_pkg::WIN_DEPTH];
        sbc_pkg::word_t a, b, s0, s1, t1, t2, e, x;
        int r;
        v = chain;
        w = window;
        for (r = 0; r < sbc_pkg::ROUNDS; r++) begin
            if (r >= sbc_pkg::WIN_DEPTH) begin
                a = w[(r - 15) % sbc_pkg::WIN_DEPTH];
                b = w[(r - 2) % sbc_pkg::WIN_DEPTH];
                s0 = spin_right(a, 1) ^ spin_right(a, 8) ^ (a >> 7);
                s1 = spin_right(b, 19) ^ spin_right(b, 61) ^ (b >> 6);
                w[r % sbc_pkg::WIN_DEPTH] = w[r % sbc_pkg::WIN_DEPTH] + s0
                    + w[(r - 7) % sbc_pkg::WIN_DEPTH] + s1;
            end
            e = v[4];
            x = v[0];
            t1 = v[7] + (spin_right(e, 14) ^ spin_right(e, 18) ^ spin_right(e, 41))
                + ((e & v[5]) ^ (~e & v[6])) + kconst[r] + w[r % sbc_pkg::WIN_DEPTH];
            t2 = (spin_right(x, 28) ^ spin_right(x, 34) ^ spin_right(x, 39))
                + ((x & v[1]) ^ (x & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        foreach (chain[i]) chain[i] = chain[i] + v[i];
    endfunction

    // One accepted message word; queues the digest when a marked block closes
    function void absorb_word(sbc_pkg::in_t w);
        sbc_pkg::out_t d;
        if (w.start_of_message) begin
            chain = init_regs;
            fill = '0;
            end_seen = 1'b0;
        end
        if (w.end_of_message) begin
            end_seen = 1'b1;
        end
        window[fill] = w.message_word;
        fill = fill + 1'b1;
        if (fill == '0) begin
            run_rounds();
            if (end_seen) begin
                end_seen = 1'b0;
                digests_predicted++;
                for (int k = 0; k < sbc_pkg::HASH_WORDS; k++) begin
                    d.digest_word  = chain[k];
                    d.digest_index = sbc_pkg::OIDX_W'(k);
                    d.last_word    = (k == sbc_pkg::HASH_WORDS - 1);
                    digests_due.push_back(d);
                end
            end
        end
    endfunction

    function void check_digest_word(sbc_pkg::out_t got);
        sbc_pkg::out_t want;
        if (digests_due.size() == 0) begin
            note_fail($sformatf("unexpected digest word: word=%h index=%0d last=%0b",
                got.digest_word, got.digest_index, got.last_word));
            return;
        end
        want = digests_due.pop_front();
        if (got.digest_word !== want.digest_word || got.digest_index !== want.digest_index
                || got.last_word !== want.last_word) begin
            note_fail($sformatf({"digest mismatch: exp word=%h index=%0d last=%0b\n",
                "                 got word=%h index=%0d last=%0b"},
                want.digest_word, want.digest_index, want.last_word,
                got.digest_word, got.digest_index, got.last_word));
        end
    endfunction

    function void check_drained();
        if (digests_due.size() != 0) begin
            note_fail($sformatf("%0d digest words never arrived", digests_due.size()));
        end
    endfunction

endclass

module sha512_block_compress_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 200;
    localparam int TOTAL_ITEMS   = 160;
    localparam int PHASES        = 4;
    localparam int MIN_DIGESTS   = 8;

    // init_hash_0 sits at index 0, the rest follow in order
    localparam int INIT_HASH_0 = 0;

    // Register settings
    localparam int CFG_ZERO    = 0;
    localparam int CFG_ONES    = 1;
    localparam int CFG_STD_IV  = 2;
    localparam int CFG_RANDOM  = 3;
    localparam int CFG_CHECKER = 4;

    logic aclk;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    sbc_pkg::in_t  s_data    = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    sbc_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    sbc_pkg::word_t cfg_data = '0;

    logic burst_mode = 1'b0;
    int   rx_hold = 0;
    int   cycle_count = 0;
    int   words_sent = 0;

    digest_tracker tracker;

    sha512_block_compress DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none in burst stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic sbc_pkg::word_t rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return sbc_pkg::word_t'(1) << $urandom_range(0, sbc_pkg::WORD_W - 1);
            3: return ~(sbc_pkg::word_t'(1) << $urandom_range(0, sbc_pkg::WORD_W - 1));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic sbc_pkg::in_t make_word(sbc_pkg::word_t d, bit sop, bit eop);
        sbc_pkg::in_t w;
        w.message_word     = d;
        w.start_of_message = sop;
        w.end_of_message   = eop;
        return w;
    endfunction

    // Result side: check each transfer, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_digest_word(m_data);
        end
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    // One input transfer; returns at the edge that accepted it
    task automatic send_word(input sbc_pkg::in_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        tracker.absorb_word(w);
        words_sent++;
    endtask

    // count random words; flags land on the given offsets (-1 for none)
    task automatic send_run(input int count, input int sop_at, input int eop_at);
        for (int i = 0; i < count; i++) begin
            send_word(make_word(rand_word(), i == sop_at, i == eop_at));
        end
    endtask

    // Hold off until every digest is out and any compression has finished
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.digests_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input int idx, input sbc_pkg::word_t val);
        cfg_valid <= 1'b1;
        cfg_index <= sbc_pkg::CFG_IDX_W'(idx);
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, val);
    endtask

    // Load all init registers, then one write to an unmapped index
    task automatic program_regs(input int setting);
        sbc_pkg::word_t std_iv [sbc_pkg::HASH_WORDS];
        sbc_pkg::word_t val;
        std_iv = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                   64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                   64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
        for (int i = INIT_HASH_0; i < INIT_HASH_0 + sbc_pkg::HASH_WORDS; i++) begin
            case (setting)
                CFG_ZERO:    val = '0;
                CFG_ONES:    val = '1;
                CFG_STD_IV:  val = std_iv[i - INIT_HASH_0];
                CFG_CHECKER: val = (i % 2 == 0) ? '0 : '1;
                default:     val = rand_word();
            endcase
            write_reg(i, val);
        end
        write_reg($urandom_range(sbc_pkg::HASH_WORDS, 2 ** sbc_pkg::CFG_IDX_W - 1),
            {$urandom(), $urandom()});
        cfg_valid <= 1'b0;
    endtask

    // One random message, mostly well formed
    task automatic send_message();
        int kind;
        int blocks;
        kind = $urandom_range(0, 99);
        burst_mode <= ($urandom_range(0, 4) == 0);
        if (kind < 70) begin
            // start on the first word, end on the last of 1..3 blocks
            blocks = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
            send_run(sbc_pkg::WIN_DEPTH * blocks, 0, sbc_pkg::WIN_DEPTH * blocks - 1);
        end else if (kind < 78) begin
            // continues the current chaining value
            send_run(sbc_pkg::WIN_DEPTH, -1, sbc_pkg::WIN_DEPTH - 1);
        end else if (kind < 86) begin
            // end marked inside the block
            send_run(sbc_pkg::WIN_DEPTH, 0, $urandom_range(0, sbc_pkg::WIN_DEPTH - 2));
        end else if (kind < 93) begin
            // cut short; a later start drops it
            send_run($urandom_range(1, sbc_pkg::WIN_DEPTH - 1), 0, $urandom_range(0, 20));
        end else begin
            // noise with scattered flags
            blocks = $urandom_range(1, 20);
            for (int i = 0; i < blocks; i++) begin
                send_word(make_word(rand_word(), $urandom_range(0, 4) == 0,
                    $urandom_range(0, 4) == 0));
            end
        end
    endtask

    initial begin
        int settings [PHASES];
        settings = '{CFG_ZERO, CFG_STD_IV, CFG_RANDOM, CFG_CHECKER};
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: from reset, no start, end marked on the fourth word
        for (int i = 0; i < sbc_pkg::WIN_DEPTH; i++) begin
            case (i)
                0: send_word(make_word('0, 1'b0, 1'b0));
                1: send_word(make_word('1, 1'b0, 1'b0));
                2: send_word(make_word({(sbc_pkg::WORD_W/2){2'b10}}, 1'b0, 1'b0));
                3: send_word(make_word({(sbc_pkg::WORD_W/2){2'b01}}, 1'b0, 1'b1));
                default: send_word(make_word(rand_word(), 1'b0, 1'b0));
            endcase
        end
        wait_idle();
        program_regs(CFG_ONES);

        // Partial block with a pending end, dropped by a new start
        send_run(4, -1, 1);
        for (int i = 0; i < sbc_pkg::WIN_DEPTH; i++) begin
            case (i)
                0: send_word(make_word({1'b1, {(sbc_pkg::WORD_W-1){1'b0}}}, 1'b1, 1'b1));
                1: send_word(make_word(sbc_pkg::word_t'(1), 1'b0, 1'b0));
                2: send_word(make_word('1, 1'b0, 1'b0));
                default: send_word(make_word(rand_word(), 1'b0, 1'b0));
            endcase
        end
        wait_idle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            program_regs(settings[ph]);
            while (words_sent < (ph + 1) * (TOTAL_ITEMS / PHASES)) begin
                if ($urandom_range(0, 9) == 0) begin
                    wait_idle();
                end
                send_message();
            end
            wait_idle();
        end
        while (tracker.digests_predicted < MIN_DIGESTS) begin
            send_run(sbc_pkg::WIN_DEPTH, 0, sbc_pkg::WIN_DEPTH - 1);
        end

        wait_idle();
        tracker.check_drained();
        if (tracker.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sbc_pkg.sv
sv/sbc_sched.sv
sv/sbc_round.sv
sv/sbc_ctrl.sv
sv/sha512_block_compress.sv
bench/sha512_block_compress_tb.sv
